>>> src/qlu_pkg.sv
// ----------------------------------------------------------------------------
// qlu_pkg
// Shared constants, types and helper functions of the Q-learning update core.
// ----------------------------------------------------------------------------
package qlu_pkg;

  localparam int NUM_STATES  = 256;
  localparam int NUM_ACTIONS = 8;

  localparam int ACTION_W = 3;
  localparam int STATE_W  = 8;
  localparam int MASK_W   = 8;
  localparam int VALUE_W  = 32;
  localparam int RATE_W   = 16;

  localparam int SIDX_W    = $clog2(NUM_STATES);
  localparam int AIDX_W    = $clog2(NUM_ACTIONS);
  localparam int TBL_AW    = SIDX_W + AIDX_W;
  localparam int TBL_DEPTH = 1 << TBL_AW;
  localparam int CNT_W     = $clog2(NUM_ACTIONS + 1);

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam int CFG_IW = CFG_AW - 2;

  localparam logic [CFG_IW-1:0] REG_LEARNING_RATE   = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] REG_DISCOUNT_FACTOR = CFG_IW'(1);

  localparam logic [RATE_W-1:0] LEARNING_RATE_RST   = 16'd6554;
  localparam logic [RATE_W-1:0] DISCOUNT_FACTOR_RST = 16'd58982;

  localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7fff_ffff;
  localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [RATE_W-1:0] learning_rate;
    logic [RATE_W-1:0] discount_factor;
  } qlu_cfg_t;

  function automatic logic [SIDX_W-1:0] clamp_state(input logic [STATE_W-1:0] s);
    if (int'(s) >= NUM_STATES) begin
      return SIDX_W'(NUM_STATES - 1);
    end
    return SIDX_W'(s);
  endfunction

  function automatic logic [AIDX_W-1:0] clamp_action(input logic [ACTION_W-1:0] a);
    if (int'(a) >= NUM_ACTIONS) begin
      return AIDX_W'(NUM_ACTIONS - 1);
    end
    return AIDX_W'(a);
  endfunction

endpackage

>>> src/qlu_in_if.sv
// ----------------------------------------------------------------------------
// qlu_in_if
// Input channel: one transaction per environment step.
// ----------------------------------------------------------------------------
interface qlu_in_if;
  import qlu_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [ACTION_W-1:0]    action_taken;
  logic [STATE_W-1:0]     next_state;
  logic signed [VALUE_W-1:0] reward;
  logic [MASK_W-1:0]      valid_mask;

  modport source (output valid, action_taken, next_state, reward, valid_mask,
                  input ready);
  modport sink   (input valid, action_taken, next_state, reward, valid_mask,
                  output ready);
endinterface

>>> src/qlu_out_if.sv
// ----------------------------------------------------------------------------
// qlu_out_if
// Result channel: one transaction per accepted input.
// ----------------------------------------------------------------------------
interface qlu_out_if;
  import qlu_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] updated_value;
  logic signed [VALUE_W-1:0] best_next_value;
  logic                      no_valid_action;

  modport source (output valid, updated_value, best_next_value, no_valid_action,
                  input ready);
  modport sink   (input valid, updated_value, best_next_value, no_valid_action,
                  output ready);
endinterface

>>> src/qlu_ram.sv
// ----------------------------------------------------------------------------
// qlu_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module qlu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/qlu_cfg.sv
// ----------------------------------------------------------------------------
// qlu_cfg
// APB register file: learning rate and discount factor.
// ----------------------------------------------------------------------------
module qlu_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [qlu_pkg::CFG_AW-1:0] paddr,
  input  logic [qlu_pkg::CFG_DW-1:0] pwdata,
  output logic [qlu_pkg::CFG_DW-1:0] prdata,
  output logic                      pready,
  output qlu_pkg::qlu_cfg_t         cfg
);
  import qlu_pkg::*;

  logic [RATE_W-1:0] lr_r;
  logic [RATE_W-1:0] df_r;
  logic [CFG_IW-1:0] idx;
  logic              wr;

  assign idx    = paddr[CFG_AW-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r <= LEARNING_RATE_RST;
      df_r <= DISCOUNT_FACTOR_RST;
    end else if (wr) begin
      if (idx == REG_LEARNING_RATE) begin
        lr_r <= pwdata[RATE_W-1:0];
      end
      if (idx == REG_DISCOUNT_FACTOR) begin
        df_r <= pwdata[RATE_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (idx == REG_LEARNING_RATE) begin
      prdata = CFG_DW'(lr_r);
    end else if (idx == REG_DISCOUNT_FACTOR) begin
      prdata = CFG_DW'(df_r);
    end
  end

  assign cfg.learning_rate   = lr_r;
  assign cfg.discount_factor = df_r;

endmodule

>>> src/tabular_q_learning_update_core.sv
// ----------------------------------------------------------------------------
// tabular_q_learning_update_core
// Tabular Q-learning update engine around a single Q-table RAM.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : valid/ready transaction with action_taken, next_state, reward and
//            valid_mask. out_ch : one result transaction per input with the
//            updated Q value, the best next value and the empty-mask flag.
//   APB    : learning_rate at 0x0, discount_factor at 0x4 (Q0.16).
// Timing:
//   After accept the sequencer reads NUM_ACTIONS entries of next_state, one per
//   cycle through the single RAM read port, then the entry being updated,
//   then passes through the arithmetic states QCAP, DIFF, MUL and SUM and
//   writes back. in_ch.ready returns in the same cycle that out_ch.valid rises,
//   so a new input is taken only after the previous one has been written back.
// Reset:
//   rst_n (synchronous) starts a clearing pass over all TBL_DEPTH entries (2048),
//   one entry per cycle, during which in_ch.ready stays low.
// Stall:
//   A finished result sits in the output register; the next input may be
//   accepted meanwhile, but its write-back waits until that result is taken.
// ----------------------------------------------------------------------------
module tabular_q_learning_update_core (
  input  logic                       clk,
  input  logic                       rst_n,
  qlu_in_if.sink                     in_ch,
  qlu_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [qlu_pkg::CFG_AW-1:0] paddr,
  input  logic [qlu_pkg::CFG_DW-1:0] pwdata,
  output logic [qlu_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import qlu_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_SCAN  = 8'b0000_0100,
    S_QCAP  = 8'b0000_1000,
    S_DIFF  = 8'b0001_0000,
    S_MUL   = 8'b0010_0000,
    S_SUM   = 8'b0100_0000,
    S_WB    = 8'b1000_0000
  } qlu_state_t;

  qlu_cfg_t cfg;

  qlu_state_t state_r, state_nxt;
  logic [TBL_AW-1:0] clr_cnt_r;
  logic [CNT_W-1:0]  scan_cnt_r;

  logic [AIDX_W-1:0]         act_r;
  logic [SIDX_W-1:0]         ns_r;
  logic [SIDX_W-1:0]         prev_r;
  logic signed [VALUE_W-1:0] reward_r;
  logic [MASK_W-1:0]         mask_r;
  logic                      found_r;
  logic signed [VALUE_W-1:0] best_r;
  logic signed [VALUE_W-1:0] q_r;
  logic signed [48:0]        prod1_r;
  logic signed [33:0]        diff_r;
  logic signed [50:0]        prod2_r;
  logic signed [VALUE_W-1:0] res_r;

  logic                      out_valid_r;
  logic signed [VALUE_W-1:0] out_upd_r;
  logic signed [VALUE_W-1:0] out_best_r;
  logic                      out_nva_r;

  logic                      in_acc;
  logic                      wb_go;
  logic                      ram_we;
  logic [TBL_AW-1:0]         ram_waddr;
  logic [VALUE_W-1:0]        ram_wdata;
  logic [TBL_AW-1:0]         ram_raddr;
  logic [VALUE_W-1:0]        ram_rdata;
  logic [CNT_W-1:0]          pa;
  logic [31:0]               mask_ext;
  logic                      take;
  logic signed [VALUE_W-1:0] rd_val;
  logic signed [VALUE_W-1:0] future;
  logic signed [33:0]        step;
  logic signed [34:0]        sum;

  qlu_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  qlu_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TBL_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign wb_go       = (state_r == S_WB) && (!out_valid_r || out_ch.ready);

  assign ram_we    = (state_r == S_CLEAR) || wb_go;
  assign ram_waddr = (state_r == S_CLEAR) ? clr_cnt_r : {prev_r, act_r};
  assign ram_wdata = (state_r == S_CLEAR) ? '0 : res_r;
  assign ram_raddr = (scan_cnt_r == CNT_W'(NUM_ACTIONS)) ? {prev_r, act_r}
                                                         : {ns_r, AIDX_W'(scan_cnt_r)};

  // scan: entry for action scan_cnt_r - 1 arrives this cycle
  assign pa       = scan_cnt_r - CNT_W'(1);
  assign mask_ext = 32'(mask_r);
  assign rd_val   = $signed(ram_rdata);
  assign take     = (state_r == S_SCAN) && (scan_cnt_r != '0) && mask_ext[5'(pa)];

  assign future = found_r ? prod1_r[47:16] : '0;
  assign step   = prod2_r[49:16];
  assign sum    = 35'(q_r) + 35'(step);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_cnt_r == TBL_AW'(TBL_DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (in_acc) state_nxt = S_SCAN;
      S_SCAN:  if (scan_cnt_r == CNT_W'(NUM_ACTIONS)) state_nxt = S_QCAP;
      S_QCAP:  state_nxt = S_DIFF;
      S_DIFF:  state_nxt = S_MUL;
      S_MUL:   state_nxt = S_SUM;
      S_SUM:   state_nxt = S_WB;
      S_WB:    if (wb_go) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      scan_cnt_r  <= '0;
      prev_r      <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + TBL_AW'(1);
      end
      if (in_acc) begin
        scan_cnt_r <= '0;
        found_r    <= 1'b0;
      end else if (state_r == S_SCAN) begin
        scan_cnt_r <= scan_cnt_r + CNT_W'(1);
        if (take) begin
          found_r <= 1'b1;
        end
      end
      if (wb_go) begin
        prev_r      <= ns_r;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r    <= clamp_action(in_ch.action_taken);
      ns_r     <= clamp_state(in_ch.next_state);
      reward_r <= in_ch.reward;
      mask_r   <= in_ch.valid_mask;
    end
    if (take && (!found_r || rd_val > best_r)) begin
      best_r <= rd_val;
    end
    if (state_r == S_QCAP) begin
      q_r     <= rd_val;
      prod1_r <= $signed({1'b0, cfg.discount_factor}) * best_r;
    end
    if (state_r == S_DIFF) begin
      diff_r <= 34'(reward_r) + 34'(future) - 34'(q_r);
    end
    if (state_r == S_MUL) begin
      prod2_r <= $signed({1'b0, cfg.learning_rate}) * diff_r;
    end
    if (state_r == S_SUM) begin
      if (sum[34:31] == 4'b0000 || sum[34:31] == 4'b1111) begin
        res_r <= sum[31:0];
      end else if (sum[34]) begin
        res_r <= VALUE_MIN;
      end else begin
        res_r <= VALUE_MAX;
      end
    end
    if (wb_go) begin
      out_upd_r  <= res_r;
      out_best_r <= found_r ? best_r : '0;
      out_nva_r  <= !found_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.updated_value   = out_upd_r;
  assign out_ch.best_next_value = out_best_r;
  assign out_ch.no_valid_action = out_nva_r;

`ifndef ASSERT_OFF
  a_we_src: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLEAR || state_r == S_WB))
    else $error("table write outside clear or write-back");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_WB))
    else $error("result without write-back");

  a_nva_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_nva_r) |-> (out_best_r == '0))
    else $error("empty mask with nonzero best value");

  a_scan_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_QCAP) |-> ($past(scan_cnt_r) == CNT_W'(NUM_ACTIONS)))
    else $error("scan ended early");
`endif

endmodule
